@@ rtl/padded_strided_sum_pool_defines.svh @@
// Assertion macros for the checker file of the sum pool block.
`ifndef PADDED_STRIDED_SUM_POOL_DEFINES_SVH
`define PADDED_STRIDED_SUM_POOL_DEFINES_SVH

// Checked property, quiet while reset is high
`define PSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("psp assertion failed");

// Checked property, also active through reset
`define PSP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("psp assertion failed");

`endif

@@ rtl/psp_pkg.sv @@
// Package of the sum pool block: defaults, widths, codes and shared types.
package psp_pkg;

   // Default capacity of the block
   localparam int DEF_MAX_WINDOW   = 8;
   localparam int DEF_MAX_WIDTH    = 64;
   localparam int DEF_MAX_CHANNELS = 16;
   localparam int DEF_MAX_HEIGHT   = 4096;

   // Divider operand width (padded height minus window)
   localparam int DIV_W   = 14;
   localparam int DIV_CW  = 4;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_WINDOW  = 3'd0,
      CSR_PAD     = 3'd1,
      CSR_STEP    = 3'd2,
      CSR_CHANNEL = 3'd3,
      CSR_HEIGHT  = 3'd4,
      CSR_WIDTH   = 3'd5
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVR,
      ST_DIVC,
      ST_SETUP,
      ST_SUM,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Request to the divider
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] numer;
      logic [3:0]       denom;
   } div_req_type;

endpackage

@@ rtl/psp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module psp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/psp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the output count.
module psp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  psp_pkg::div_req_type      req,
   output logic                      done,
   output logic [psp_pkg::DIV_W-1:0] quot
);
   import psp_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [3:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [3:0]        den_ff, den_in;
   logic [4:0]        shifted;
   logic              fits;

   // One shift-subtract step per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(DIV_W - 1);
         rem_in  = 4'd0;
         quo_in  = req.numer;
         den_in  = req.denom;
      end else if (busy_ff) begin
         rem_in = fits ? 4'(shifted - {1'b0, den_ff}) : shifted[3:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

@@ rtl/padded_strided_sum_pool.sv @@
// Top level of the padded, strided 2-D sum pool over channel-innermost images.
//
//  channel | direction | ports                          | handshake
//  req     | in        | req_pixel_value                | req_valid / req_stall
//  rsp     | out       | rsp_window_sum, row, col, ...  | rsp_valid / rsp_stall
//  csr     | in        | csr_index, csr_wdata           | csr_we, no wait
//
// An item is stored as it is taken; each output that it completes then takes a setup
// step, a window walk with one store read a cycle on the single RAM read port, a drain
// step and a hand-over. After reset and after every register write the block computes
// the output grid size with a serial divider before it takes an item.
// Reset is synchronous; the store is not cleared. A stalled result holds the
// sequencer in its hand-over state once the next window has been summed.
module padded_strided_sum_pool #(
   parameter int MAX_WINDOW   = psp_pkg::DEF_MAX_WINDOW,
   parameter int MAX_WIDTH    = psp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = psp_pkg::DEF_MAX_CHANNELS,
   parameter int MAX_HEIGHT   = psp_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_window_sum,
   output logic [12:0] rsp_out_row,
   output logic [6:0]  rsp_out_col,
   output logic [3:0]  rsp_out_channel,
   output logic        rsp_image_done,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import psp_pkg::*;

   localparam int Depth = MAX_WINDOW * MAX_WIDTH * MAX_CHANNELS;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   function automatic logic [AddrW-1:0] addr_of(logic [SlotW-1:0] slot, logic [6:0] x,
                                                logic [4:0] ch);
      return AddrW'((int'(slot) * MAX_WIDTH + int'(x)) * MAX_CHANNELS + int'(ch));
   endfunction

   // Configuration registers
   logic [3:0]  win_ff, step_ff;
   logic [2:0]  pad_ff;
   logic [4:0]  chn_ff;
   logic [12:0] hgt_ff;
   logic [6:0]  wid_ff;

   // Effective configuration
   logic [4:0]  f;
   logic [3:0]  s;
   logic [2:0]  p;
   logic [4:0]  nc;
   logic [12:0] h;
   logic [6:0]  w;

   always_comb begin
      if (win_ff == 4'd0) f = 5'd1;
      else if (32'(win_ff) > MAX_WINDOW) f = 5'(MAX_WINDOW);
      else f = {1'b0, win_ff};
      s = (step_ff == 4'd0) ? 4'd1 : step_ff;
      p = ({2'b0, pad_ff} >= f) ? 3'(f - 5'd1) : pad_ff;
      if (chn_ff == 5'd0) nc = 5'd1;
      else if (32'(chn_ff) > MAX_CHANNELS) nc = 5'(MAX_CHANNELS);
      else nc = chn_ff;
      if (hgt_ff == 13'd0) h = 13'd1;
      else if (32'(hgt_ff) > MAX_HEIGHT) h = 13'(MAX_HEIGHT);
      else h = hgt_ff;
      if (wid_ff == 7'd0) w = 7'd1;
      else if (32'(wid_ff) > MAX_WIDTH) w = 7'(MAX_WIDTH);
      else w = wid_ff;
   end

   // State and control registers
   state_type         state_ff, state_in;
   logic              dirty_ff, dirty_in;
   logic [12:0]       row_ff, row_in;
   logic [6:0]        col_ff, col_in;
   logic [4:0]        chc_ff, chc_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [DIV_W-1:0]  rq_ff, rq_in;
   logic [3:0]        rrem_ff, rrem_in;
   logic [7:0]        cq_ff, cq_in;
   logic [3:0]        crem_ff, crem_in;
   logic [DIV_W-1:0]  outh_ff;
   logic [7:0]        outw_ff;
   logic              rd_pend_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Item and window registers
   logic [12:0]      it_r_ff;
   logic [6:0]       it_c_ff;
   logic [4:0]       it_ch_ff;
   logic [SlotW-1:0] it_slot_ff;
   logic [DIV_W-1:0] oh_ff, rhi_ff;
   logic [7:0]       ow_ff, clo_ff, chi_ff;
   logic [12:0]      y0_ff, y_ff;
   logic [6:0]       x0_ff, x_ff;
   logic [SlotW-1:0] sc_ff;
   logic [63:0]      acc_ff;
   logic [63:0]      rsp_sum_ff;
   logic [12:0]      rsp_row_ff;
   logic [6:0]       rsp_col_ff;
   logic [3:0]       rsp_ch_ff;
   logic             rsp_done_ff, rsp_last_ff;

   // Divider and store
   div_req_type      div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic [63:0]      rd_data;

   psp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   psp_ram #(.WIDTH(64), .DEPTH(Depth)) u_store (
      .clock (clock),
      .we    (req_valid && !req_stall),
      .waddr (wr_addr),
      .wdata (req_pixel_value),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // Current position, ranges of completed outputs, next position
   logic [12:0]      cur_r, r_nx;
   logic [6:0]       cur_c, c_nx;
   logic [4:0]       cur_ch, ch_nx;
   logic [SlotW-1:0] cur_slot;
   logic [15:0]      row_t;
   logic [9:0]       col_t, col_t_nx;
   logic [15:0]      row_t_nx;
   logic             rv, cv, c_adv, r_adv;
   logic [DIV_W-1:0] rlo, rhi;
   logic [7:0]       clo, chi;
   logic [DIV_W-1:0] row_numer, col_numer;
   logic             row_ok, col_ok;

   always_comb begin
      cur_r    = (row_ff >= h) ? 13'd0 : row_ff;
      cur_slot = (row_ff >= h) ? '0 : slot_ff;
      cur_c    = (col_ff >= w) ? 7'd0 : col_ff;
      cur_ch   = (chc_ff >= nc) ? 5'd0 : chc_ff;
      wr_addr  = addr_of(cur_slot, cur_c, cur_ch);
      row_t    = 16'(cur_r) + 16'(p) + 16'd1 - 16'(f);
      col_t    = 10'(cur_c) + 10'(p) + 10'd1 - 10'(f);

      // Rows whose window closes on this row
      if (cur_r != h - 13'd1) begin
         rlo = rq_ff;
         rhi = rq_ff;
         rv  = !row_t[15] && rrem_ff == 4'd0 && rq_ff < outh_ff;
      end else begin
         if (row_t[15] || row_t == 16'd0) rlo = '0;
         else rlo = (rrem_ff == 4'd0) ? rq_ff : rq_ff + DIV_W'(1);
         rhi = outh_ff - DIV_W'(1);
         rv  = outh_ff != '0 && rlo <= rhi;
      end

      // Columns whose window closes on this column
      if (cur_c != w - 7'd1) begin
         clo = cq_ff;
         chi = cq_ff;
         cv  = !col_t[9] && crem_ff == 4'd0 && cq_ff < outw_ff;
      end else begin
         if (col_t[9] || col_t == 10'd0) clo = 8'd0;
         else clo = (crem_ff == 4'd0) ? cq_ff : cq_ff + 8'd1;
         chi = outw_ff - 8'd1;
         cv  = outw_ff != 8'd0 && clo <= chi;
      end

      // Raster advance
      c_adv = (cur_ch + 5'd1) == nc;
      ch_nx = c_adv ? 5'd0 : cur_ch + 5'd1;
      r_adv = c_adv && (cur_c + 7'd1) == w;
      c_nx  = c_adv ? (r_adv ? 7'd0 : cur_c + 7'd1) : cur_c;
      r_nx  = r_adv ? (((cur_r + 13'd1) == h) ? 13'd0 : cur_r + 13'd1) : cur_r;
      row_t_nx = 16'(r_nx) + 16'(p) + 16'd1 - 16'(f);
      col_t_nx = 10'(c_nx) + 10'(p) + 10'd1 - 10'(f);

      // Output grid size numerators
      row_ok    = (14'(h) + 14'({p, 1'b0})) >= 14'(f);
      col_ok    = (14'(w) + 14'({p, 1'b0})) >= 14'(f);
      row_numer = row_ok ? 14'(h) + 14'({p, 1'b0}) - 14'(f) : '0;
      col_numer = col_ok ? 14'(w) + 14'({p, 1'b0}) - 14'(f) : '0;
   end

   // Sequencer: next state
   logic sum_end, out_free, accept;
   assign sum_end  = x_ff == x0_ff && y_ff == y0_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) state_in = ST_IDLE;
            else if (dirty_ff) state_in = ST_DIVR;
            else if (accept && rv && cv) state_in = ST_SETUP;
         end
         ST_DIVR: begin
            if (csr_we) state_in = ST_IDLE;
            else if (div_done) state_in = ST_DIVC;
         end
         ST_DIVC: begin
            if (csr_we || div_done) state_in = ST_IDLE;
         end
         ST_SETUP: state_in = ST_SUM;
         ST_SUM: begin
            if (sum_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (ow_ff == chi_ff && oh_ff == rhi_ff) state_in = ST_IDLE;
               else state_in = ST_SETUP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_stall     = !(state_ff == ST_IDLE && !dirty_ff);
      div_req.start = (state_ff == ST_IDLE && dirty_ff && !csr_we) ||
                      (state_ff == ST_DIVR && div_done && !csr_we);
      div_req.numer = (state_ff == ST_IDLE) ? row_numer : col_numer;
      div_req.denom = s;
      rd_addr       = addr_of(sc_ff, x_ff, it_ch_ff);
   end

   // Control registers and position counters
   always_comb begin
      dirty_in = dirty_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      chc_in   = chc_ff;
      slot_in  = slot_ff;
      rq_in    = rq_ff;
      rrem_in  = rrem_ff;
      cq_in    = cq_ff;
      crem_in  = crem_ff;
      if (csr_we) begin
         dirty_in = 1'b1;
         // Only a write to a real register restarts the image
         if (csr_index <= CSR_WIDTH) begin
            row_in  = 13'd0;
            col_in  = 7'd0;
            chc_in  = 5'd0;
            slot_in = '0;
            rq_in   = '0;
            rrem_in = 4'd0;
            cq_in   = 8'd0;
            crem_in = 4'd0;
         end
      end else begin
         if (state_ff == ST_DIVC && div_done) dirty_in = 1'b0;
         if (accept) begin
            row_in = r_nx;
            col_in = c_nx;
            chc_in = ch_nx;
            if (r_adv) begin
               if (r_nx == 13'd0) slot_in = '0;
               else if (32'(cur_slot) == MAX_WINDOW - 1) slot_in = '0;
               else slot_in = cur_slot + SlotW'(1);
               if (row_t_nx == 16'd0) begin
                  rq_in   = '0;
                  rrem_in = 4'd0;
               end else if (!row_t_nx[15]) begin
                  if (rrem_ff + 4'd1 == s) begin
                     rrem_in = 4'd0;
                     rq_in   = rq_ff + DIV_W'(1);
                  end else begin
                     rrem_in = rrem_ff + 4'd1;
                  end
               end
            end
            if (c_adv) begin
               if (col_t_nx == 10'd0) begin
                  cq_in   = 8'd0;
                  crem_in = 4'd0;
               end else if (!col_t_nx[9]) begin
                  if (crem_ff + 4'd1 == s) begin
                     crem_in = 4'd0;
                     cq_in   = cq_ff + 8'd1;
                  end else begin
                     crem_in = crem_ff + 4'd1;
                  end
               end
            end
         end
      end
      rsp_valid_in = (state_ff == ST_EMIT && out_free) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b1;
         row_ff       <= 13'd0;
         col_ff       <= 7'd0;
         chc_ff       <= 5'd0;
         slot_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= 4'd2;
         pad_ff       <= 3'd0;
         step_ff      <= 4'd2;
         chn_ff       <= 5'd1;
         hgt_ff       <= 13'd8;
         wid_ff       <= 7'd8;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         chc_ff       <= chc_in;
         slot_ff      <= slot_in;
         rd_pend_ff   <= state_ff == ST_SUM;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_WINDOW:  win_ff  <= csr_wdata[3:0];
               CSR_PAD:     pad_ff  <= csr_wdata[2:0];
               CSR_STEP:    step_ff <= csr_wdata[3:0];
               CSR_CHANNEL: chn_ff  <= csr_wdata[4:0];
               CSR_HEIGHT:  hgt_ff  <= csr_wdata;
               CSR_WIDTH:   wid_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
      rq_ff   <= rq_in;
      rrem_ff <= rrem_in;
      cq_ff   <= cq_in;
      crem_ff <= crem_in;
   end

   // Datapath: grid size, item capture, window walk, accumulation, result register
   logic [17:0] prod_r;
   logic [11:0] prod_c;
   assign prod_r = 18'(oh_ff) * 18'(s);
   assign prod_c = 12'(ow_ff) * 12'(s);

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIVR && div_done) outh_ff <= row_ok ? div_quot + DIV_W'(1) : '0;
      if (state_ff == ST_DIVC && div_done) outw_ff <= col_ok ? 8'(div_quot) + 8'd1 : 8'd0;
      if (accept) begin
         it_r_ff    <= cur_r;
         it_c_ff    <= cur_c;
         it_ch_ff   <= cur_ch;
         it_slot_ff <= cur_slot;
         oh_ff      <= rlo;
         rhi_ff     <= rhi;
         ow_ff      <= clo;
         clo_ff     <= clo;
         chi_ff     <= chi;
      end
      case (state_ff)
         ST_SETUP: begin
            y0_ff  <= (prod_r >= 18'(p)) ? 13'(prod_r - 18'(p)) : 13'd0;
            x0_ff  <= (prod_c >= 12'(p)) ? 7'(prod_c - 12'(p)) : 7'd0;
            y_ff   <= it_r_ff;
            x_ff   <= it_c_ff;
            sc_ff  <= it_slot_ff;
            acc_ff <= 64'd0;
         end
         ST_SUM: begin
            if (x_ff == x0_ff) begin
               x_ff  <= it_c_ff;
               y_ff  <= y_ff - 13'd1;
               sc_ff <= (sc_ff == '0) ? SlotW'(MAX_WINDOW - 1) : sc_ff - SlotW'(1);
            end else begin
               x_ff <= x_ff - 7'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (ow_ff == chi_ff) begin
                  ow_ff <= clo_ff;
                  oh_ff <= oh_ff + DIV_W'(1);
               end else begin
                  ow_ff <= ow_ff + 8'd1;
               end
            end
         end
         default: ;
      endcase
      if (rd_pend_ff) acc_ff <= acc_ff + rd_data;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_sum_ff  <= acc_ff;
         rsp_row_ff  <= 13'(oh_ff);
         rsp_col_ff  <= 7'(ow_ff);
         rsp_ch_ff   <= 4'(it_ch_ff);
         rsp_done_ff <= oh_ff == outh_ff - DIV_W'(1) && ow_ff == outw_ff - 8'd1 &&
                        it_ch_ff == nc - 5'd1;
         rsp_last_ff <= oh_ff == rhi_ff && ow_ff == chi_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_sum  = rsp_sum_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_image_done  = rsp_done_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

@@ rtl/psp_checker.sv @@
// Port-level checker of the sum pool block, bound to its top level.
`include "padded_strided_sum_pool_defines.svh"

module psp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_window_sum,
   input logic [12:0] rsp_out_row,
   input logic        rsp_image_done,
   input logic        rsp_last,
   input logic        csr_we
);
   // Grid size is recomputed after reset and after any write before input is taken
   `PSP_ASSERT_ALWAYS(a_reset_stall, clock, reset |=> req_stall)
   `PSP_ASSERT(a_csr_stall, clock, reset, csr_we |=> req_stall)
   // The final output of an image is always the last one of its transaction
   `PSP_ASSERT(a_done_last, clock, reset, (rsp_valid && rsp_image_done) |-> rsp_last)
   // Held result transaction
   `PSP_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)
   `PSP_ASSERT(a_rsp_stable, clock, reset,
      (rsp_valid && rsp_stall) |=> ($stable(rsp_window_sum) && $stable(rsp_out_row)))
endmodule

bind padded_strided_sum_pool psp_checker u_psp_checker (.*);

@@ test/tb_padded_strided_sum_pool.sv @@
// Testbench of the padded, strided sum pool: directed table, random phases, scoreboard.
module tb_padded_strided_sum_pool;
   timeunit 1ns;
   timeprecision 1ps;
   import psp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_ITEMS   = 128;
   localparam int QUIET_FROM     = 100;
   localparam int ROW_SLOTS      = 8;
   localparam int STORE_COLS     = 64;
   localparam int STORE_CHANS    = 16;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [63:0] window_sum;
      logic [12:0] out_row;
      logic [6:0]  out_col;
      logic [3:0]  out_channel;
      logic        image_done;
      logic        last;
   } pool_result_type;

   typedef struct {
      bit          is_csr;
      logic [2:0]  idx;
      logic [12:0] data;
      logic [63:0] pixel;
      bit          typed;
      logic [63:0] sum;
   } pool_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_pixel_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_window_sum;
   logic [12:0] rsp_out_row;
   logic [6:0]  rsp_out_col;
   logic [3:0]  rsp_out_channel;
   logic        rsp_image_done;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   // Tag carried alongside the payload for rows with a hand-typed sum
   logic        req_typed = 1'b0;
   logic [63:0] req_typed_sum = '0;

   bit          quiet = 1'b0;
   int          failures = 0;
   int          stalled_cycles = 0;
   int          random_sent = 0;

   pool_result_type pending_sums[$];

   // Shadow of the block: registers, ring of rows and position counters
   logic [3:0]  cfg_window = 4'd2;
   logic [2:0]  cfg_pad = 3'd0;
   logic [3:0]  cfg_step = 4'd2;
   logic [4:0]  cfg_chans = 5'd1;
   logic [12:0] cfg_height = 13'd8;
   logic [6:0]  cfg_width = 7'd8;
   logic [63:0] ring_rows [ROW_SLOTS*STORE_COLS*STORE_CHANS];
   int          pos_row = 0, pos_col = 0, pos_chan = 0;

   padded_strided_sum_pool dut (.*);

   always #1 clock = ~clock;

   function automatic int clamp_cfg(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int grid_size(int n, int f, int p, int s);
      if (n + 2*p < f) return 0;
      return (n + 2*p - f) / s + 1;
   endfunction

   // Outputs whose clipped window ends at position x along one axis
   function automatic bit span_ends(int x, int n, int f, int p, int s, int outn,
                                    output int lo, output int hi);
      int t;
      t = x + p + 1 - f;
      lo = 0;
      hi = -1;
      if (outn <= 0) return 0;
      if (x < n - 1) begin
         if (t < 0 || t % s != 0 || t / s >= outn) return 0;
         lo = t / s;
         hi = t / s;
         return 1;
      end
      lo = (t <= 0) ? 0 : (t + s - 1) / s;
      hi = outn - 1;
      return lo <= hi;
   endfunction

   function automatic int ring_addr(int row, int col, int ch);
      return ((row % ROW_SLOTS) * STORE_COLS + col) * STORE_CHANS + ch;
   endfunction

   // Store one pixel and queue every window sum it completes
   function automatic void pool_pixel(logic [63:0] pixel);
      int f, p, s, nc, h, w, r, c, ch, outh, outw, rlo, rhi, clo, chi, y0, x0;
      logic [63:0] acc;
      pool_result_type res;
      f  = clamp_cfg(cfg_window, 8);
      p  = cfg_pad;
      s  = clamp_cfg(cfg_step, 15);
      nc = clamp_cfg(cfg_chans, 16);
      h  = clamp_cfg(cfg_height, 4096);
      w  = clamp_cfg(cfg_width, 64);
      if (p >= f) p = f - 1;
      r  = (pos_row >= h) ? 0 : pos_row;
      c  = (pos_col >= w) ? 0 : pos_col;
      ch = (pos_chan >= nc) ? 0 : pos_chan;
      ring_rows[ring_addr(r, c, ch)] = pixel;
      outh = grid_size(h, f, p, s);
      outw = grid_size(w, f, p, s);
      if (span_ends(r, h, f, p, s, outh, rlo, rhi) &&
          span_ends(c, w, f, p, s, outw, clo, chi)) begin
         for (int oh = rlo; oh <= rhi; oh++) begin
            for (int ow = clo; ow <= chi; ow++) begin
               y0 = oh*s - p;
               x0 = ow*s - p;
               if (y0 < 0) y0 = 0;
               if (x0 < 0) x0 = 0;
               acc = '0;
               for (int y = y0; y <= r; y++)
                  for (int x = x0; x <= c; x++)
                     acc += ring_rows[ring_addr(y, x, ch)];
               res.window_sum  = acc;
               res.out_row     = 13'(oh);
               res.out_col     = 7'(ow);
               res.out_channel = 4'(ch);
               res.image_done  = (oh == outh-1 && ow == outw-1 && ch == nc-1);
               res.last        = (oh == rhi && ow == chi);
               pending_sums.push_back(res);
            end
         end
      end
      ch++;
      if (ch >= nc) begin
         ch = 0;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
      end
      pos_row = r;
      pos_col = c;
      pos_chan = ch;
   endfunction

   // Track register writes and accepted pixels at each edge
   always @(posedge clock) begin
      int before_n;
      if (!reset && csr_we) begin
         if (csr_index <= CSR_WIDTH) begin
            case (csr_index)
               CSR_WINDOW:  cfg_window = csr_wdata[3:0];
               CSR_PAD:     cfg_pad    = csr_wdata[2:0];
               CSR_STEP:    cfg_step   = csr_wdata[3:0];
               CSR_CHANNEL: cfg_chans  = csr_wdata[4:0];
               CSR_HEIGHT:  cfg_height = csr_wdata;
               CSR_WIDTH:   cfg_width  = csr_wdata[6:0];
               default: ;
            endcase
            pos_row = 0;
            pos_col = 0;
            pos_chan = 0;
         end
      end
      if (!reset && req_valid && !req_stall) begin
         before_n = pending_sums.size();
         pool_pixel(req_pixel_value);
         if (req_typed)
            for (int k = before_n; k < pending_sums.size(); k++)
               pending_sums[k].window_sum = req_typed_sum;
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result sum %h row %0d col %0d ch %0d", $realtime,
                     rsp_window_sum, rsp_out_row, rsp_out_col, rsp_out_channel);
            failures++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_window_sum !== want.window_sum) begin
               $display("%0t: window_sum expected %h actual %h", $realtime,
                        want.window_sum, rsp_window_sum);
               failures++;
            end
            if (rsp_out_row !== want.out_row) begin
               $display("%0t: out_row expected %0d actual %0d", $realtime,
                        want.out_row, rsp_out_row);
               failures++;
            end
            if (rsp_out_col !== want.out_col) begin
               $display("%0t: out_col expected %0d actual %0d", $realtime,
                        want.out_col, rsp_out_col);
               failures++;
            end
            if (rsp_out_channel !== want.out_channel) begin
               $display("%0t: out_channel expected %0d actual %0d", $realtime,
                        want.out_channel, rsp_out_channel);
               failures++;
            end
            if (rsp_image_done !== want.image_done) begin
               $display("%0t: image_done expected %b actual %b", $realtime,
                        want.image_done, rsp_image_done);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %b actual %b", $realtime, want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side back-pressure in bursts
   initial begin
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   task automatic drain_pool();
      req_valid <= 1'b0;
      req_typed <= 1'b0;
      @(posedge clock);
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [12:0] data);
      drain_pool();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [63:0] pixel, bit typed, logic [63:0] sum);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pixel;
      req_typed       <= typed;
      req_typed_sum   <= sum;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_geometry(int f, int p, int s, int c, int h, int w);
      write_reg(CSR_WINDOW, 13'(f));
      write_reg(CSR_PAD, 13'(p));
      write_reg(CSR_STEP, 13'(s));
      write_reg(CSR_CHANNEL, 13'(c));
      write_reg(CSR_HEIGHT, 13'(h));
      write_reg(CSR_WIDTH, 13'(w));
   endtask

   pool_row_type script[$];

   function automatic void add_reg(logic [2:0] idx, logic [12:0] data);
      script.push_back('{1'b1, idx, data, 64'd0, 1'b0, 64'd0});
   endfunction

   function automatic void add_pix(logic [63:0] pixel, bit typed, logic [63:0] sum);
      script.push_back('{1'b0, 3'd0, 13'd0, pixel, typed, sum});
   endfunction

   initial begin
      int f, p, s, c, h, w, lowest, n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: first two rows of an 8x8 single channel image
      for (int i = 0; i < 16; i++) send_pixel({$urandom, $urandom}, 1'b0, 64'd0);

      // 2x2 image, one 2x2 window: wrap-around and all-zero sums
      add_reg(CSR_WINDOW, 13'd2); add_reg(CSR_PAD, 13'd0); add_reg(CSR_STEP, 13'd2);
      add_reg(CSR_CHANNEL, 13'd1); add_reg(CSR_HEIGHT, 13'd2); add_reg(CSR_WIDTH, 13'd2);
      for (int i = 0; i < 4; i++) add_pix('1, i == 3, 64'hFFFF_FFFF_FFFF_FFFC);
      for (int i = 0; i < 4; i++) add_pix('0, i == 3, 64'd0);
      // Single pixel under heavy padding: nine windows all see just it
      add_reg(CSR_WINDOW, 13'd3); add_reg(CSR_PAD, 13'd2); add_reg(CSR_STEP, 13'd1);
      add_reg(CSR_HEIGHT, 13'd1); add_reg(CSR_WIDTH, 13'd1);
      add_pix(64'h8000_0000_0000_0001, 1'b1, 64'h8000_0000_0000_0001);
      // All registers zero but pad, which exceeds the window: clamped to a 1x1 pass-through
      add_reg(CSR_WINDOW, 13'd0); add_reg(CSR_PAD, 13'd5); add_reg(CSR_STEP, 13'd0);
      add_reg(CSR_CHANNEL, 13'd0); add_reg(CSR_HEIGHT, 13'd0); add_reg(CSR_WIDTH, 13'd0);
      add_pix(64'h5555_AAAA_5555_AAAA, 1'b1, 64'h5555_AAAA_5555_AAAA);
      // Window, channel, height and width above range, pad and step at their largest: clamped
      add_reg(CSR_WINDOW, 13'd15); add_reg(CSR_PAD, 13'd7); add_reg(CSR_STEP, 13'd15);
      add_reg(CSR_CHANNEL, 13'd31); add_reg(CSR_HEIGHT, 13'd8191);
      add_reg(CSR_WIDTH, 13'd127);
      for (int i = 0; i < 3; i++) add_pix(64'h0123_4567_89AB_CDEF, 1'b0, 64'd0);
      // Writes to unused indexes leave geometry and position alone
      add_reg(CSR_SPARE_LO, 13'd8191); add_reg(CSR_SPARE_HI, 13'd0);
      add_pix(64'hDEAD_BEEF_0000_FFFF, 1'b0, 64'd0);
      // Padded image smaller than the window: no outputs
      add_reg(CSR_WINDOW, 13'd8); add_reg(CSR_PAD, 13'd0); add_reg(CSR_STEP, 13'd1);
      add_reg(CSR_CHANNEL, 13'd1); add_reg(CSR_HEIGHT, 13'd1); add_reg(CSR_WIDTH, 13'd1);
      add_pix(64'hFEDC_BA98_7654_3210, 1'b0, 64'd0);

      foreach (script[i]) begin
         if (script[i].is_csr)
            write_reg(script[i].idx, script[i].data);
         else
            send_pixel(script[i].pixel, script[i].typed, script[i].sum);
      end

      // Random geometries, mostly whole small images with dense outputs
      while (random_sent < RANDOM_ITEMS) begin
         f = $urandom_range(1, 8);
         p = $urandom_range(0, f - 1);
         s = $urandom_range(1, 8);
         c = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 3);
         lowest = (f - 2*p > 1) ? f - 2*p : 1;
         h = $urandom_range(lowest, lowest + 3);
         w = $urandom_range(lowest, lowest + 3);
         // Occasionally a pad of f - 1 or more to hit its clamping, or a step of zero or above 8
         if ($urandom_range(0, 5) == 0) p = $urandom_range(f - 1, 7);
         if ($urandom_range(0, 5) == 0) s = ($urandom_range(0, 1) == 0) ? 0
                                                                       : $urandom_range(9, 15);
         set_geometry(f, p, s, c, h, w);
         n = h * w * c;
         if (n > 48) n = 48;
         for (int i = 0; i < n && random_sent < RANDOM_ITEMS; i++) begin
            send_pixel({$urandom, $urandom}, 1'b0, 64'd0);
            random_sent++;
            if (random_sent >= QUIET_FROM) quiet = 1'b1;
         end
      end

      drain_pool();
      if (failures == 0 && pending_sums.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
